/* rtl/core/peit_pkg.sv */
// Shared constants, codes and state type for the prime exponent integrality tracker.
package peit_pkg;

  // Default sizes
  localparam int VALUE_MAX_DEF     = 65535;
  localparam int EXPONENT_BITS_DEF = 32;

  // Fixed field widths
  localparam int KIND_W  = 2;
  localparam int VALUE_W = 17;
  localparam int COUNT_W = 16;

  // Generation tag kept next to each exponent; an entry whose tag differs is zero
  localparam int EPOCH_BITS = 8;

  // Request kinds
  localparam logic [KIND_W-1:0] KIND_MUL   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DIV   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_START = 2'd2;

  typedef enum logic [3:0] {
    ST_INIT,   // write identity factors and zero exponents
    ST_PCHK,   // read candidate prime
    ST_PEVAL,  // test candidate prime
    ST_MRD,    // read multiple of prime
    ST_MWR,    // mark multiple of prime
    ST_IDLE,   // wait for request
    ST_CLR,    // sweep exponent memory when the tag wraps
    ST_APPLY,  // sort out zero and out of range values
    ST_FRD,    // read factor table
    ST_FEXP,   // read exponent of the factor
    ST_FUPD,   // write exponent back
    ST_DONE    // present result
  } state_t;

endpackage

/* rtl/core/prime_exponent_integrality_tracker.sv */
// Top level: sieve-built factor table and per-prime exponent tracking.
//
//  channel  | ports                                     | handshake
//  ---------+-------------------------------------------+----------------------------
//  request  | in_kind, in_value                         | taken when start & !busy
//  result   | out_is_integer, out_negative_prime_count  | out_valid for one cycle
//
//  Each prime factor of the magnitude, counted with repeats (at most 15 at the default
//  size), costs a factor table read, an exponent read and an exponent write-back through
//  the single-port-per-direction memories before out_valid rises. A start that finds
//  the generation tag at its last value (every 255th start) first sweeps the exponent
//  memory. After reset busy stays high while the sieve runs: it fills the table, then
//  tests each candidate up to sqrt(VALUE_MAX) and marks the multiples of each prime.
//  Results are not held: the receiver takes out_valid in the cycle it is shown.
module prime_exponent_integrality_tracker #(
  parameter int VALUE_MAX     = peit_pkg::VALUE_MAX_DEF,
  parameter int EXPONENT_BITS = peit_pkg::EXPONENT_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [peit_pkg::KIND_W-1:0]         in_kind,
  input  logic signed [peit_pkg::VALUE_W-1:0] in_value,
  output logic                                out_valid,
  output logic                                out_is_integer,
  output logic [peit_pkg::COUNT_W-1:0]        out_negative_prime_count
);

  import peit_pkg::*;

  localparam int AW    = $clog2(VALUE_MAX + 1);
  localparam int DEPTH = VALUE_MAX + 1;
  localparam int SW    = 2 * AW;
  localparam int EW    = EPOCH_BITS + EXPONENT_BITS;

  localparam logic [AW-1:0]            VMAX_A     = AW'(VALUE_MAX);
  localparam logic [AW:0]              VMAX_J     = (AW + 1)'(VALUE_MAX);
  localparam logic [2*AW-1:0]          VMAX_SQ    = (2 * AW)'(VALUE_MAX);
  localparam logic [EPOCH_BITS-1:0]    EPOCH_LAST = '1;
  localparam logic [EPOCH_BITS-1:0]    EPOCH_ONE  = EPOCH_BITS'(1);
  localparam logic [EXPONENT_BITS-1:0] EXP_HI     = {1'b0, {(EXPONENT_BITS - 1){1'b1}}};
  localparam logic [EXPONENT_BITS-1:0] EXP_LO     = {1'b1, {(EXPONENT_BITS - 1){1'b0}}};
  localparam logic [COUNT_W-1:0]       COUNT_SAT  = '1;

  // Control and datapath registers
  state_t                   state_r, state_nxt;
  logic [AW-1:0]            a_r, a_nxt;
  logic [AW-1:0]            i_r, i_nxt;
  logic [AW:0]              j_r, j_nxt;
  logic [AW-1:0]            q_r, q_nxt;
  logic [AW-1:0]            cur_r, cur_nxt;
  logic [AW-1:0]            p_r, p_nxt;
  logic [KIND_W-1:0]        kind_r, kind_nxt;
  logic [VALUE_W-1:0]       mag_r, mag_nxt;
  logic [EPOCH_BITS-1:0]    epoch_r, epoch_nxt;
  logic [AW-1:0]            negcnt_r, negcnt_nxt;
  logic                     zl_r, zl_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic                     out_int_r, out_int_nxt;
  logic [COUNT_W-1:0]       out_cnt_r, out_cnt_nxt;

  // Memory ports
  logic                     spf_we;
  logic [AW-1:0]            spf_waddr, spf_raddr;
  logic [SW-1:0]            spf_wdata, spf_rd;
  logic                     exp_we;
  logic [AW-1:0]            exp_waddr, exp_raddr;
  logic [EW-1:0]            exp_wdata, exp_rd;

  // Derived values
  logic [VALUE_W-1:0]       in_raw, in_mag;
  logic [2*AW-1:0]          sq;
  logic [AW-1:0]            rd_fac, rd_quo;
  logic [EPOCH_BITS-1:0]    rd_tag;
  logic [EXPONENT_BITS-1:0] e_cur, e_new;
  logic                     raise;
  logic                     mag_skip;

  // Factor table: {smallest factor, value / smallest factor}
  peit_ram #(.WIDTH(SW), .DEPTH(DEPTH)) u_spf_ram (
    .clk   (clk),
    .we    (spf_we),
    .waddr (spf_waddr),
    .wdata (spf_wdata),
    .raddr (spf_raddr),
    .rdata (spf_rd)
  );

  // Exponent table: {generation tag, signed exponent}
  peit_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_exp_ram (
    .clk   (clk),
    .we    (exp_we),
    .waddr (exp_waddr),
    .wdata (exp_wdata),
    .raddr (exp_raddr),
    .rdata (exp_rd)
  );

  // Magnitude of the operand
  assign in_raw = in_value;
  assign in_mag = in_raw[VALUE_W-1] ? (~in_raw + VALUE_W'(1)) : in_raw;

  assign sq     = i_r * i_r;
  assign rd_fac = spf_rd[SW-1:AW];
  assign rd_quo = spf_rd[AW-1:0];
  assign rd_tag = exp_rd[EW-1:EXPONENT_BITS];

  // Stale generation reads as zero
  assign e_cur = (rd_tag == epoch_r) ? exp_rd[EXPONENT_BITS-1:0] : '0;
  assign raise = (kind_r != KIND_DIV);

  // Saturating step
  always_comb begin
    e_new = e_cur;
    if (raise) begin
      if (e_cur != EXP_HI) begin
        e_new = e_cur + EXPONENT_BITS'(1);
      end
    end else begin
      if (e_cur != EXP_LO) begin
        e_new = e_cur - EXPONENT_BITS'(1);
      end
    end
  end

  assign mag_skip = (mag_r == '0) || (32'(mag_r) > 32'(VALUE_MAX));

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_INIT: begin
        if (a_r == VMAX_A) state_nxt = ST_PCHK;
      end
      ST_PCHK: begin
        state_nxt = (sq > VMAX_SQ) ? ST_IDLE : ST_PEVAL;
      end
      ST_PEVAL: begin
        state_nxt = (rd_fac == i_r) ? ST_MRD : ST_PCHK;
      end
      ST_MRD: begin
        state_nxt = (j_r > VMAX_J) ? ST_PCHK : ST_MWR;
      end
      ST_MWR: begin
        state_nxt = ST_MRD;
      end
      ST_IDLE: begin
        if (start) begin
          if (in_kind == KIND_START && epoch_r == EPOCH_LAST) begin
            state_nxt = ST_CLR;
          end else if (in_kind == KIND_START || in_kind == KIND_MUL ||
                       in_kind == KIND_DIV) begin
            state_nxt = ST_APPLY;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_CLR: begin
        if (a_r == VMAX_A) state_nxt = ST_APPLY;
      end
      ST_APPLY: begin
        state_nxt = mag_skip ? ST_DONE : ST_FRD;
      end
      ST_FRD: begin
        state_nxt = (cur_r > AW'(1)) ? ST_FEXP : ST_DONE;
      end
      ST_FEXP: begin
        state_nxt = (rd_fac < AW'(2)) ? ST_DONE : ST_FUPD;
      end
      ST_FUPD: begin
        state_nxt = ST_FRD;
      end
      ST_DONE: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Datapath and memory control
  always_comb begin
    a_nxt         = a_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    q_nxt         = q_r;
    cur_nxt       = cur_r;
    p_nxt         = p_r;
    kind_nxt      = kind_r;
    mag_nxt       = mag_r;
    epoch_nxt     = epoch_r;
    negcnt_nxt    = negcnt_r;
    zl_nxt        = zl_r;
    out_valid_nxt = 1'b0;
    out_int_nxt   = out_int_r;
    out_cnt_nxt   = out_cnt_r;
    spf_we        = 1'b0;
    spf_waddr     = a_r;
    spf_wdata     = '0;
    spf_raddr     = cur_r;
    exp_we        = 1'b0;
    exp_waddr     = a_r;
    exp_wdata     = '0;
    exp_raddr     = rd_fac;
    case (state_r)
      ST_INIT: begin
        // Fill identity entries and stale exponents
        spf_we    = 1'b1;
        spf_wdata = (a_r < AW'(2)) ? '0 : {a_r, AW'(1)};
        exp_we    = 1'b1;
        a_nxt     = (a_r == VMAX_A) ? '0 : a_r + AW'(1);
        i_nxt     = AW'(2);
      end
      ST_PCHK: begin
        spf_raddr = i_r;
        j_nxt     = (AW + 1)'(sq);
      end
      ST_PEVAL: begin
        if (rd_fac == i_r) begin
          q_nxt = i_r;
        end else begin
          i_nxt = i_r + AW'(1);
        end
      end
      ST_MRD: begin
        spf_raddr = j_r[AW-1:0];
        if (j_r > VMAX_J) i_nxt = i_r + AW'(1);
      end
      ST_MWR: begin
        // Mark only entries no smaller prime has claimed
        if (rd_fac == j_r[AW-1:0]) begin
          spf_we    = 1'b1;
          spf_waddr = j_r[AW-1:0];
          spf_wdata = {i_r, q_r};
        end
        j_nxt = j_r + {1'b0, i_r};
        q_nxt = q_r + AW'(1);
      end
      ST_IDLE: begin
        a_nxt = '0;
        if (start) begin
          kind_nxt = in_kind;
          mag_nxt  = in_mag;
          if (in_kind == KIND_START) begin
            negcnt_nxt = '0;
            zl_nxt     = 1'b0;
            if (epoch_r != EPOCH_LAST) epoch_nxt = epoch_r + EPOCH_ONE;
          end
        end
      end
      ST_CLR: begin
        exp_we = 1'b1;
        a_nxt  = (a_r == VMAX_A) ? '0 : a_r + AW'(1);
        if (a_r == VMAX_A) epoch_nxt = EPOCH_ONE;
      end
      ST_APPLY: begin
        if (mag_r == '0) zl_nxt = 1'b1;
        cur_nxt = AW'(mag_r);
      end
      ST_FRD: begin
        spf_raddr = cur_r;
      end
      ST_FEXP: begin
        exp_raddr = rd_fac;
        p_nxt     = rd_fac;
        cur_nxt   = rd_quo;
      end
      ST_FUPD: begin
        // Write back and track sign changes
        exp_we    = 1'b1;
        exp_waddr = p_r;
        exp_wdata = {epoch_r, e_new};
        if (e_cur[EXPONENT_BITS-1] && !e_new[EXPONENT_BITS-1]) begin
          negcnt_nxt = negcnt_r - AW'(1);
        end else if (!e_cur[EXPONENT_BITS-1] && e_new[EXPONENT_BITS-1]) begin
          negcnt_nxt = negcnt_r + AW'(1);
        end
      end
      ST_DONE: begin
        out_valid_nxt = 1'b1;
        out_int_nxt   = zl_r || (negcnt_r == '0);
        out_cnt_nxt   = (32'(negcnt_r) > 32'(COUNT_SAT)) ? COUNT_SAT : COUNT_W'(negcnt_r);
      end
      default: begin
        a_nxt = '0;
      end
    endcase
  end

  // Registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      a_r         <= '0;
      epoch_r     <= EPOCH_ONE;
      negcnt_r    <= '0;
      zl_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      a_r         <= a_nxt;
      epoch_r     <= epoch_nxt;
      negcnt_r    <= negcnt_nxt;
      zl_r        <= zl_nxt;
      out_valid_r <= out_valid_nxt;
    end
    i_r       <= i_nxt;
    j_r       <= j_nxt;
    q_r       <= q_nxt;
    cur_r     <= cur_nxt;
    p_r       <= p_nxt;
    kind_r    <= kind_nxt;
    mag_r     <= mag_nxt;
    out_int_r <= out_int_nxt;
    out_cnt_r <= out_cnt_nxt;
  end

  // Drive ports
  assign busy                     = (state_r != ST_IDLE);
  assign out_valid                = out_valid_r;
  assign out_is_integer           = out_int_r;
  assign out_negative_prime_count = out_cnt_r;

endmodule

/* rtl/core/peit_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
module peit_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, then register the read word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
